@@ hw/rtl/dnv_pkg.sv @@
package dnv_pkg;

   localparam int CHAR_W = 16;
   localparam int LLEN_W = 7;
   localparam int NLEN_W = 9;
   localparam int SLL_W = 6;
   localparam int NLL_W = 8;
   localparam int CSR_DATA_W = 8;
   localparam int STORE_DEPTH = 128;
   localparam int STORE_AW = 7;

   localparam logic [LLEN_W-1:0] LLEN_MAX = 7'd127;
   localparam logic [NLEN_W-1:0] NLEN_MAX = 9'd511;
   localparam logic [LLEN_W-1:0] LABEL_MAX = 7'd63;
   localparam logic [SLL_W-1:0] SLL_RESET = 6'd15;
   localparam logic [NLL_W-1:0] NLL_RESET = 8'd253;

   localparam logic CSR_SINGLE_LABEL = 1'b0;
   localparam logic CSR_NAME_LENGTH = 1'b1;

   localparam logic [7:0] ASC_DOT = 8'h2E;
   localparam logic [7:0] ASC_HYPHEN = 8'h2D;
   localparam logic [7:0] ASC_UNDERSCORE = 8'h5F;
   localparam logic [7:0] ASC_X = 8'h78;
   localparam logic [7:0] ASC_N = 8'h6E;

   localparam logic [31:0] PUNY_BASE = 32'd36;
   localparam logic [31:0] PUNY_SKEW = 32'd38;
   localparam logic [31:0] PUNY_ADAPT_LIM = 32'd455;
   // reciprocals: x/700 = ((x >> 2) * M700) >> 38, x/35 = (x * (2^32 + M35_LO)) >> 38
   localparam logic [31:0] PUNY_M700 = 32'd1570730897;
   localparam logic [31:0] PUNY_M35_LO = 32'hD41D41D5;
   localparam logic [20:0] PUNY_N0 = 21'd128;
   localparam logic [9:0] PUNY_BIAS0 = 10'd72;
   localparam logic [4:0] PUNY_TMIN = 5'd1;
   localparam logic [4:0] PUNY_TMAX = 5'd26;
   localparam logic [32:0] MAX_CP = 33'h10FFFF;
   localparam logic [32:0] SUR_LO = 33'hD800;
   localparam logic [32:0] SUR_HI = 33'hDFFF;

   typedef struct packed {
      logic puny;
      logic last;
      logic bank;
      logic [5:0] len;
      logic fail;
      logic dot;
   } job_type;

   typedef struct packed {
      logic valid;
      logic bank;
   } done_type;

   function automatic logic [7:0] to_lower(input logic [7:0] c);
      to_lower = (c >= 8'h41 && c <= 8'h5A) ? (c + 8'd32) : c;
   endfunction

   // {ok, value}
   function automatic logic [6:0] digit_value(input logic [7:0] c);
      logic [7:0] l;
      l = to_lower(c);
      if (l >= 8'h61 && l <= 8'h7A) begin
         digit_value = {1'b1, 6'(l - 8'h61)};
      end else if (l >= 8'h30 && l <= 8'h39) begin
         digit_value = {1'b1, 6'(l - 8'h30 + 8'd26)};
      end else begin
         digit_value = 7'd0;
      end
   endfunction

endpackage

@@ hw/rtl/dnv_ram.sv @@
module dnv_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule

@@ hw/rtl/dnv_front.sv @@
module dnv_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [15:0]                   req_char_code,
   input  logic                          req_is_last,
   input  logic                          csr_we,
   input  logic                          csr_index,
   input  logic [7:0]                    csr_wdata,
   output dnv_pkg::job_type              job,
   output logic                          job_push,
   input  logic                          job_full,
   input  dnv_pkg::done_type             done,
   output logic                          ram_we,
   output logic [dnv_pkg::STORE_AW-1:0]  ram_waddr,
   output logic [7:0]                    ram_wdata
);
   import dnv_pkg::*;

   logic [LLEN_W-1:0] llen_ff, llen_in;
   logic [NLEN_W-1:0] nlen_ff, nlen_in;
   logic [NLEN_W-1:0] pend_ff, pend_in;
   logic              fh_ff, fh_in, lh_ff, lh_in, und_ff, und_in;
   logic [3:0]        pre_ff, pre_in;
   logic              dot_ff, dot_in, fail_ff, fail_in;
   logic              bank_ff, bank_in;
   logic [1:0]        busy_ff, busy_in;
   logic [SLL_W-1:0]  sll_ff;
   logic [NLL_W-1:0]  nll_ff;

   logic              accept, is_dot, ch_ok;
   logic [7:0]        ch_b;
   logic [1:0]        chk_a, chk_b;
   logic [NLEN_W:0]   nsum;

   // {fail, needs decode}
   function automatic logic [1:0] close_check(input logic [LLEN_W-1:0] len,
      input logic fh, input logic lh, input logic [3:0] pre, input logic und);
      logic f, p;
      f = (len == '0) || (len > LABEL_MAX) || fh || lh;
      p = 1'b0;
      if (!f && len >= 7'd4 && (&pre)) begin
         if (und || len == 7'd4) begin
            f = 1'b1;
         end else begin
            p = 1'b1;
         end
      end
      close_check = {f, p};
   endfunction

   function automatic logic prefix_match(input logic [1:0] idx, input logic [7:0] b);
      logic m;
      unique case (idx)
         2'd0: m = (to_lower(b) == ASC_X);
         2'd1: m = (to_lower(b) == ASC_N);
         default: m = (b == ASC_HYPHEN);
      endcase
      prefix_match = m;
   endfunction

   assign ch_b = req_char_code[7:0];
   assign is_dot = (req_char_code == {8'h00, ASC_DOT});
   assign ch_ok = (req_char_code[15:8] == 8'h00) &&
      ((ch_b >= 8'h61 && ch_b <= 8'h7A) || (ch_b >= 8'h41 && ch_b <= 8'h5A) ||
       (ch_b >= 8'h30 && ch_b <= 8'h39) || ch_b == ASC_HYPHEN || ch_b == ASC_UNDERSCORE);

   // hold when the job queue is full or the bank a new label may use is still being decoded
   assign req_stall = job_full || busy_ff[bank_ff] || ((pend_ff != '0) && busy_ff[~bank_ff]);
   assign accept = req_valid && !req_stall;
   assign ram_wdata = ch_b;

   always_comb begin
      llen_in = llen_ff;
      nlen_in = nlen_ff;
      pend_in = pend_ff;
      fh_in = fh_ff;
      lh_in = lh_ff;
      und_in = und_ff;
      pre_in = pre_ff;
      dot_in = dot_ff;
      fail_in = fail_ff;
      bank_in = bank_ff;
      busy_in = busy_ff;
      job = '0;
      job_push = 1'b0;
      ram_we = 1'b0;
      ram_waddr = '0;
      chk_a = '0;
      chk_b = '0;
      nsum = '0;
      if (done.valid) begin
         busy_in[done.bank] = 1'b0;
      end
      if (accept) begin
         if (is_dot) begin
            if (pend_ff != NLEN_MAX) begin
               pend_in = pend_ff + 9'd1;
            end
         end else begin
            if (pend_ff != '0) begin
               dot_in = 1'b1;
               if (pend_ff > 9'd1) begin
                  fail_in = 1'b1;
               end
               chk_a = close_check(llen_ff, fh_ff, lh_ff, pre_ff, und_ff);
               if (chk_a[1]) begin
                  fail_in = 1'b1;
               end
               if (chk_a[0]) begin
                  job_push = 1'b1;
                  job.puny = 1'b1;
                  job.bank = bank_ff;
                  job.len = llen_ff[5:0];
                  bank_in = ~bank_ff;
               end
               nsum = {1'b0, nlen_ff} + {1'b0, pend_ff};
               nlen_in = (nsum > {1'b0, NLEN_MAX}) ? NLEN_MAX : nsum[NLEN_W-1:0];
               pend_in = '0;
               llen_in = '0;
               fh_in = 1'b0;
               lh_in = 1'b0;
               und_in = 1'b0;
               pre_in = '0;
            end
            if (!ch_ok) begin
               fail_in = 1'b1;
            end
            if (llen_in < 7'd64) begin
               ram_we = 1'b1;
               ram_waddr = {bank_in, llen_in[5:0]};
            end
            if (llen_in == '0) begin
               fh_in = (ch_b == ASC_HYPHEN);
            end
            lh_in = (ch_b == ASC_HYPHEN);
            if (req_char_code == {8'h00, ASC_UNDERSCORE}) begin
               und_in = 1'b1;
            end
            if (llen_in < 7'd4) begin
               pre_in[llen_in[1:0]] = prefix_match(llen_in[1:0], ch_b);
            end
            if (llen_in != LLEN_MAX) begin
               llen_in = llen_in + 7'd1;
            end
            if (llen_in > LABEL_MAX) begin
               fail_in = 1'b1;
            end
            if (nlen_in != NLEN_MAX) begin
               nlen_in = nlen_in + 9'd1;
            end
         end
         if (req_is_last) begin
            if (nlen_in == '0) begin
               fail_in = 1'b1;
            end else begin
               chk_b = close_check(llen_in, fh_in, lh_in, pre_in, und_in);
               if (chk_b[1]) begin
                  fail_in = 1'b1;
               end
               if (chk_b[0]) begin
                  job.puny = 1'b1;
                  job.bank = bank_in;
                  job.len = llen_in[5:0];
                  bank_in = ~bank_in;
               end
            end
            if (nlen_in > {1'b0, nll_ff}) begin
               fail_in = 1'b1;
            end
            if (!dot_in && nlen_in > {3'b000, sll_ff}) begin
               fail_in = 1'b1;
            end
            job_push = 1'b1;
            job.last = 1'b1;
            job.fail = fail_in;
            job.dot = dot_in;
            llen_in = '0;
            nlen_in = '0;
            pend_in = '0;
            fh_in = 1'b0;
            lh_in = 1'b0;
            und_in = 1'b0;
            pre_in = '0;
            dot_in = 1'b0;
            fail_in = 1'b0;
         end
         if (job_push && job.puny) begin
            busy_in[job.bank] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         llen_ff <= '0;
         nlen_ff <= '0;
         pend_ff <= '0;
         fh_ff <= 1'b0;
         lh_ff <= 1'b0;
         und_ff <= 1'b0;
         pre_ff <= '0;
         dot_ff <= 1'b0;
         fail_ff <= 1'b0;
         bank_ff <= 1'b0;
         busy_ff <= '0;
         sll_ff <= SLL_RESET;
         nll_ff <= NLL_RESET;
      end else begin
         llen_ff <= llen_in;
         nlen_ff <= nlen_in;
         pend_ff <= pend_in;
         fh_ff <= fh_in;
         lh_ff <= lh_in;
         und_ff <= und_in;
         pre_ff <= pre_in;
         dot_ff <= dot_in;
         fail_ff <= fail_in;
         bank_ff <= bank_in;
         busy_ff <= busy_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_SINGLE_LABEL: sll_ff <= csr_wdata[SLL_W-1:0];
               CSR_NAME_LENGTH: nll_ff <= csr_wdata;
               default: nll_ff <= nll_ff;
            endcase
         end
      end
   end
endmodule

@@ hw/rtl/dnv_queue.sv @@
module dnv_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  dnv_pkg::job_type push_job,
   output logic             full,
   input  logic             pop,
   output dnv_pkg::job_type head_job,
   output logic             head_valid
);
   import dnv_pkg::*;

   job_type    slot_ff [2];
   logic       wp_ff, rp_ff;
   logic [1:0] cnt_ff;

   assign full = (cnt_ff == 2'd2);
   assign head_valid = (cnt_ff != 2'd0);
   assign head_job = slot_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wp_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) begin
            wp_ff <= ~wp_ff;
         end
         if (pop) begin
            rp_ff <= ~rp_ff;
         end
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
   end
endmodule

@@ hw/rtl/dnv_div.sv @@
module dnv_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] dividend,
   input  logic [31:0] divisor,
   output logic        done,
   output logic [31:0] quotient,
   output logic [31:0] remainder
);
   logic        busy_ff, done_ff;
   logic [4:0]  cnt_ff;
   logic [31:0] dvd_ff, dvs_ff, rem_ff;
   logic [32:0] rem_sh, rem_sub;
   logic        ge;

   assign rem_sh = {rem_ff, dvd_ff[31]};
   assign rem_sub = rem_sh - {1'b0, dvs_ff};
   assign ge = (rem_sh >= {1'b0, dvs_ff});
   assign done = done_ff;
   assign quotient = dvd_ff;
   assign remainder = rem_ff;

   always_ff @(posedge clock) begin
      if (start) begin
         dvd_ff <= dividend;
         dvs_ff <= divisor;
         rem_ff <= '0;
      end else if (busy_ff) begin
         dvd_ff <= {dvd_ff[30:0], ge};
         rem_ff <= ge ? rem_sub[31:0] : rem_sh[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end
endmodule

@@ hw/rtl/dnv_back.sv @@
module dnv_back (
   input  logic                          clock,
   input  logic                          reset,
   input  dnv_pkg::job_type              head_job,
   input  logic                          head_valid,
   output logic                          pop,
   output dnv_pkg::done_type             done,
   output logic [dnv_pkg::STORE_AW-1:0]  ram_raddr,
   input  logic [7:0]                    ram_rdata,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_name_valid,
   output logic                          rsp_has_dot
);
   import dnv_pkg::*;

   localparam logic [4:0] ST_IDLE   = 5'd0;
   localparam logic [4:0] ST_SCAN_A = 5'd1;
   localparam logic [4:0] ST_SCAN_D = 5'd2;
   localparam logic [4:0] ST_DEC    = 5'd3;
   localparam logic [4:0] ST_LOOP   = 5'd4;
   localparam logic [4:0] ST_DIG_A  = 5'd5;
   localparam logic [4:0] ST_DIG_D  = 5'd6;
   localparam logic [4:0] ST_WMUL   = 5'd7;
   localparam logic [4:0] ST_AD0    = 5'd8;
   localparam logic [4:0] ST_WPTS   = 5'd10;
   localparam logic [4:0] ST_AD2    = 5'd11;
   localparam logic [4:0] ST_WB     = 5'd13;
   localparam logic [4:0] ST_WN     = 5'd14;
   localparam logic [4:0] ST_FIN    = 5'd15;
   localparam logic [4:0] ST_EMIT   = 5'd16;

   logic [4:0]  st_ff, st_in;
   job_type     job_ff, job_in;
   logic        pfail_ff, pfail_in, acc_ff, acc_in;
   logic [5:0]  pos_ff, pos_in, plen_ff, plen_in, delim_ff, delim_in;
   logic        hasd_ff, hasd_in;
   logic [6:0]  out_ff, out_in;
   logic [20:0] n_ff, n_in;
   logic [31:0] i_ff, i_in, oldi_ff, oldi_in, w_ff, w_in, delta_ff, delta_in;
   logic [11:0] k_ff, k_in;
   logic [9:0]  bias_ff, bias_in, kacc_ff, kacc_in;
   logic [4:0]  t_ff, t_in;
   logic        rv_ff, rv_in, nv_ff, nv_in, hd_ff, hd_in;

   logic        div_start, div_done;
   logic [31:0] div_dvd, div_dvs, div_quo, div_rem;
   logic [6:0]  dig;
   logic [37:0] prod_i, prod_w;
   logic [38:0] isum;
   logic [4:0]  t_c;
   logic [11:0] kb;
   logic [31:0] delta_c, points;
   logic [32:0] nsum;
   logic [5:0]  wfac;
   logic [63:0] prod700;
   logic [64:0] prod35;
   logic [31:0] q700, q35;

   dnv_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dvd),
      .divisor   (div_dvs),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   assign ram_raddr = {job_ff.bank, pos_ff + 6'd4};
   assign rsp_valid = rv_ff;
   assign rsp_name_valid = nv_ff;
   assign rsp_has_dot = hd_ff;

   assign dig = digit_value(ram_rdata);
   assign prod_i = {6'd0, w_ff} * {32'd0, dig[5:0]};
   assign isum = {7'd0, i_ff} + {1'b0, prod_i};
   assign kb = {2'b00, bias_ff};
   assign t_c = (k_ff <= kb) ? PUNY_TMIN :
                (k_ff >= kb + 12'd26) ? PUNY_TMAX : 5'(k_ff - kb);
   assign wfac = 6'(PUNY_BASE) - {1'b0, t_ff};
   assign prod_w = {6'd0, w_ff} * {32'd0, wfac};
   assign delta_c = i_ff - oldi_ff;
   assign points = {25'd0, out_ff} + 32'd1;
   assign nsum = {12'd0, n_ff} + {1'b0, div_quo};

   // constant divides by 700 and 35 through reciprocal multiplication
   assign prod700 = {34'd0, delta_c[31:2]} * {32'd0, PUNY_M700};
   assign q700 = {6'd0, prod700[63:38]};
   assign prod35 = {1'b0, delta_ff, 32'd0} + {1'b0, {32'd0, delta_ff} * {32'd0, PUNY_M35_LO}};
   assign q35 = {5'd0, prod35[64:38]};

   always_comb begin
      st_in = st_ff;
      job_in = job_ff;
      pfail_in = pfail_ff;
      acc_in = acc_ff;
      pos_in = pos_ff;
      plen_in = plen_ff;
      delim_in = delim_ff;
      hasd_in = hasd_ff;
      out_in = out_ff;
      n_in = n_ff;
      i_in = i_ff;
      oldi_in = oldi_ff;
      w_in = w_ff;
      delta_in = delta_ff;
      k_in = k_ff;
      bias_in = bias_ff;
      kacc_in = kacc_ff;
      t_in = t_ff;
      rv_in = rv_ff;
      nv_in = nv_ff;
      hd_in = hd_ff;
      pop = 1'b0;
      done = '0;
      div_start = 1'b0;
      div_dvd = delta_ff;
      div_dvs = points;
      if (rv_ff && !rsp_stall) begin
         rv_in = 1'b0;
      end
      unique case (st_ff)
         ST_IDLE: begin
            if (head_valid) begin
               pop = 1'b1;
               job_in = head_job;
               pfail_in = 1'b0;
               pos_in = '0;
               hasd_in = 1'b0;
               delim_in = '0;
               plen_in = head_job.len - 6'd4;
               st_in = head_job.puny ? ST_SCAN_A : ST_EMIT;
            end
         end
         ST_SCAN_A: st_in = ST_SCAN_D;
         ST_SCAN_D: begin
            // the last hyphen splits basic code points from the digits
            if (ram_rdata == ASC_HYPHEN) begin
               hasd_in = 1'b1;
               delim_in = pos_ff;
            end
            pos_in = pos_ff + 6'd1;
            if (ram_rdata != ASC_HYPHEN && !dig[6]) begin
               pfail_in = 1'b1;
               st_in = ST_FIN;
            end else if (pos_ff + 6'd1 == plen_ff) begin
               st_in = ST_DEC;
            end else begin
               st_in = ST_SCAN_A;
            end
         end
         ST_DEC: begin
            out_in = hasd_ff ? {1'b0, delim_ff} : 7'd0;
            pos_in = hasd_ff ? delim_ff + 6'd1 : 6'd0;
            n_in = PUNY_N0;
            i_in = '0;
            bias_in = PUNY_BIAS0;
            st_in = ST_LOOP;
         end
         ST_LOOP: begin
            if (pos_ff >= plen_ff) begin
               pfail_in = (out_ff == 7'd0);
               st_in = ST_FIN;
            end else begin
               oldi_in = i_ff;
               w_in = 32'd1;
               k_in = 12'(PUNY_BASE);
               st_in = ST_DIG_A;
            end
         end
         ST_DIG_A: begin
            if (pos_ff >= plen_ff) begin
               pfail_in = 1'b1;
               st_in = ST_FIN;
            end else begin
               st_in = ST_DIG_D;
            end
         end
         ST_DIG_D: begin
            pos_in = pos_ff + 6'd1;
            i_in = isum[31:0];
            t_in = t_c;
            if (!dig[6] || (isum[38:32] != '0)) begin
               pfail_in = 1'b1;
               st_in = ST_FIN;
            end else if (dig[5:0] < {1'b0, t_c}) begin
               st_in = ST_AD0;
            end else begin
               st_in = ST_WMUL;
            end
         end
         ST_WMUL: begin
            w_in = prod_w[31:0];
            k_in = k_ff + 12'(PUNY_BASE);
            if (prod_w[37:32] != '0) begin
               pfail_in = 1'b1;
               st_in = ST_FIN;
            end else begin
               st_in = ST_DIG_A;
            end
         end
         ST_AD0: begin
            div_start = 1'b1;
            if (oldi_ff == '0) begin
               delta_in = q700;
               div_dvd = q700;
            end else begin
               delta_in = {1'b0, delta_c[31:1]};
               div_dvd = {1'b0, delta_c[31:1]};
            end
            st_in = ST_WPTS;
         end
         ST_WPTS: begin
            if (div_done) begin
               delta_in = delta_ff + div_quo;
               kacc_in = '0;
               st_in = ST_AD2;
            end
         end
         ST_AD2: begin
            if (delta_ff > PUNY_ADAPT_LIM) begin
               delta_in = q35;
               kacc_in = kacc_ff + 10'(PUNY_BASE);
            end else begin
               div_start = 1'b1;
               div_dvd = {23'd0, delta_ff[8:0]} * PUNY_BASE;
               div_dvs = delta_ff + PUNY_SKEW;
               st_in = ST_WB;
            end
         end
         ST_WB: begin
            if (div_done) begin
               bias_in = kacc_ff + div_quo[9:0];
               div_start = 1'b1;
               div_dvd = i_ff;
               st_in = ST_WN;
            end
         end
         ST_WN: begin
            if (div_done) begin
               n_in = nsum[20:0];
               i_in = div_rem + 32'd1;
               out_in = out_ff + 7'd1;
               if (nsum > MAX_CP || (nsum >= SUR_LO && nsum <= SUR_HI) ||
                   out_ff >= LABEL_MAX) begin
                  pfail_in = 1'b1;
                  st_in = ST_FIN;
               end else begin
                  st_in = ST_LOOP;
               end
            end
         end
         ST_FIN: begin
            done.valid = 1'b1;
            done.bank = job_ff.bank;
            acc_in = acc_ff | pfail_ff;
            st_in = job_ff.last ? ST_EMIT : ST_IDLE;
         end
         ST_EMIT: begin
            if (!rv_ff || !rsp_stall) begin
               rv_in = 1'b1;
               nv_in = !(job_ff.fail || acc_ff);
               hd_in = job_ff.dot;
               acc_in = 1'b0;
               st_in = ST_IDLE;
            end
         end
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
      pos_ff <= pos_in;
      plen_ff <= plen_in;
      delim_ff <= delim_in;
      hasd_ff <= hasd_in;
      out_ff <= out_in;
      n_ff <= n_in;
      i_ff <= i_in;
      oldi_ff <= oldi_in;
      w_ff <= w_in;
      delta_ff <= delta_in;
      k_ff <= k_in;
      bias_ff <= bias_in;
      kacc_ff <= kacc_in;
      t_ff <= t_in;
      pfail_ff <= pfail_in;
      nv_ff <= nv_in;
      hd_ff <= hd_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE;
         acc_ff <= 1'b0;
         rv_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         acc_ff <= acc_in;
         rv_ff <= rv_in;
      end
   end
endmodule

@@ hw/rtl/dns_name_validator.sv @@
// channel   | valid     | stall     | payload
// request   | req_valid | req_stall | req_char_code, req_is_last
// response  | rsp_valid | rsp_stall | rsp_name_valid, rsp_has_dot
//
// A character is taken while req_stall is low; a plain label closes at no extra cost.
// Closing an xn-- label queues a decode job: each stored byte is scanned in a read state
// and a data state, then each code point takes its digits through read, data and weight
// multiply states, then bias reduction steps and three passes of the radix-2 divider.
// The front keeps taking characters into the other store bank while a decode runs;
// it stalls only when it must reuse a bank still being decoded or the job queue is full.
// Synchronous reset clears all control state; the label store needs no clearing.
module dns_name_validator (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [15:0] req_char_code,
   input  logic        req_is_last,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_name_valid,
   output logic        rsp_has_dot,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [7:0]  csr_wdata
);
   import dnv_pkg::*;

   job_type             push_job, head_job;
   logic                job_push, job_full, head_valid, job_pop;
   done_type            done;
   logic                ram_we;
   logic [STORE_AW-1:0] ram_waddr, ram_raddr;
   logic [7:0]          ram_wdata, ram_rdata;

   dnv_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_char_code (req_char_code),
      .req_is_last   (req_is_last),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .job           (push_job),
      .job_push      (job_push),
      .job_full      (job_full),
      .done          (done),
      .ram_we        (ram_we),
      .ram_waddr     (ram_waddr),
      .ram_wdata     (ram_wdata)
   );

   dnv_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (job_push),
      .push_job   (push_job),
      .full       (job_full),
      .pop        (job_pop),
      .head_job   (head_job),
      .head_valid (head_valid)
   );

   dnv_ram #(
      .WIDTH (8),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   dnv_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head_job       (head_job),
      .head_valid     (head_valid),
      .pop            (job_pop),
      .done           (done),
      .ram_raddr      (ram_raddr),
      .ram_rdata      (ram_rdata),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_name_valid (rsp_name_valid),
      .rsp_has_dot    (rsp_has_dot)
   );
endmodule

@@ hw/rtl/dnv_checker.sv @@
module dnv_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_stall,
   input logic rsp_valid,
   input logic rsp_stall,
   input logic rsp_name_valid,
   input logic rsp_has_dot
);
   // an empty block takes the first request at once
   a_ready_after_reset: assert property (@(posedge clock) reset |=> !req_stall)
      else $error("request stalled right after reset");

   a_no_rsp_after_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response offered right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid)
      else $error("stalled response dropped");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> ($stable(rsp_name_valid) && $stable(rsp_has_dot)))
      else $error("stalled response changed");
endmodule

bind dns_name_validator dnv_checker u_dnv_checker (.*);

@@ bench/testbench.sv @@
module testbench;
   import dnv_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LONG_IDLE_CYCLES = 400;
   localparam int DRAIN_CYCLES = 3000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [15:0] req_char_code = '0;
   logic        req_is_last = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_name_valid;
   logic        rsp_has_dot;
   logic        csr_we = 1'b0;
   logic        csr_index = CSR_SINGLE_LABEL;
   logic [7:0]  csr_wdata = '0;

   dns_name_validator DUT (.*);

   always #5 clock = ~clock;

   typedef struct packed {
      logic name_valid;
      logic has_dot;
   } verdict_type;

   typedef struct {
      logic [15:0] ch;
      logic        last;
      logic        known;
      verdict_type want;
   } stim_row_type;

   // predictor state
   logic [SLL_W-1:0] single_limit;
   logic [NLL_W-1:0] name_limit;
   logic [7:0]  lbl [64];
   int unsigned lbl_len, nm_len, dots_held;
   logic [7:0]  lbl_first, lbl_last;
   bit          lbl_under, nm_dot, nm_bad;

   verdict_type verdicts_due[$];
   int          fail_count = 0;
   bit          quiet = 1'b0;
   bit          hold_rsp = 1'b0;
   int          accepted = 0;

   task automatic report(input string what);
      $display("mismatch at %0t: %s", $realtime, what);
      fail_count++;
   endtask

   function automatic logic [7:0] lower8(input logic [7:0] c);
      return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
   endfunction

   function automatic int b36(input logic [7:0] c);
      logic [7:0] l;
      l = lower8(c);
      if (l >= "a" && l <= "z") return l - "a";
      if (l >= "0" && l <= "9") return l - "0" + 26;
      return -1;
   endfunction

   function automatic longint unsigned adapt_bias(input longint unsigned delta,
         input longint unsigned pts, input bit first);
      longint unsigned k;
      k = 0;
      delta = first ? delta / 700 : delta / 2;
      delta += delta / pts;
      while (delta > 455) begin
         delta /= 35;
         k += 36;
      end
      return k + (36 * delta) / (delta + 38);
   endfunction

   function automatic bit puny_decodes();
      longint unsigned plen, delim, outn, n, i, bias, pos, oldi, w, k, t, ud, q;
      longint unsigned lim;
      bit has_delim;
      int d;
      lim = 64'hFFFF_FFFF;
      if (lbl_len <= 4 || lbl_len > 63) return 0;
      plen = lbl_len - 4;
      has_delim = 0;
      delim = 0;
      for (longint unsigned p = 0; p < plen; p++) begin
         if (lbl[4 + p] == "-") begin
            has_delim = 1;
            delim = p;
         end else if (b36(lbl[4 + p]) < 0) return 0;
      end
      outn = has_delim ? delim : 0;
      n = 128;
      i = 0;
      bias = 72;
      pos = has_delim ? delim + 1 : 0;
      while (pos < plen) begin
         oldi = i;
         w = 1;
         k = 36;
         forever begin
            if (pos >= plen) return 0;
            d = b36(lbl[4 + pos]);
            pos++;
            if (d < 0) return 0;
            ud = d;
            if (ud > (lim - i) / w) return 0;
            i += ud * w;
            t = (k <= bias) ? 1 : (k >= bias + 26) ? 26 : k - bias;
            if (ud < t) break;
            if (w > lim / (36 - t)) return 0;
            w *= 36 - t;
            k += 36;
         end
         bias = adapt_bias(i - oldi, outn + 1, oldi == 0);
         q = i / (outn + 1);
         if (q > lim - n) return 0;
         n += q;
         i %= outn + 1;
         if (n > 64'h10FFFF || (n >= 64'hD800 && n <= 64'hDFFF)) return 0;
         outn++;
         if (outn > 63) return 0;
         i++;
      end
      return outn > 0;
   endfunction

   function automatic void end_label();
      if (lbl_len == 0 || lbl_len > 63 || lbl_first == "-" || lbl_last == "-") begin
         nm_bad = 1;
         return;
      end
      if (lbl_len >= 4 && lower8(lbl[0]) == "x" && lower8(lbl[1]) == "n" &&
          lbl[2] == "-" && lbl[3] == "-")
         if (lbl_under || !puny_decodes()) nm_bad = 1;
   endfunction

   function automatic void clear_name_state();
      lbl_len = 0; lbl_first = 0; lbl_last = 0; lbl_under = 0;
      nm_len = 0; dots_held = 0; nm_dot = 0; nm_bad = 0;
   endfunction

   // returns 1 and fills v when the character ends a name
   function automatic bit validate_char(input logic [15:0] c, input logic last,
         output verdict_type v);
      bit ok;
      v = '0;
      if (c == 16'h002E) begin
         if (dots_held < 511) dots_held++;
      end else begin
         ok = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
              (c >= "0" && c <= "9") || c == "-" || c == "_";
         if (dots_held != 0) begin
            nm_dot = 1;
            if (dots_held > 1) nm_bad = 1;
            end_label();
            nm_len = (nm_len + dots_held > 511) ? 511 : nm_len + dots_held;
            dots_held = 0;
            lbl_len = 0; lbl_first = 0; lbl_last = 0; lbl_under = 0;
         end
         if (!ok) nm_bad = 1;
         if (lbl_len < 64) lbl[lbl_len] = c[7:0];
         if (lbl_len == 0) lbl_first = c[7:0];
         lbl_last = c[7:0];
         if (c == "_") lbl_under = 1;
         if (lbl_len < 127) lbl_len++;
         if (lbl_len > 63) nm_bad = 1;
         if (nm_len < 511) nm_len++;
      end
      if (!last) return 0;
      if (nm_len == 0) nm_bad = 1;
      else end_label();
      if (nm_len > name_limit) nm_bad = 1;
      if (!nm_dot && nm_len > single_limit) nm_bad = 1;
      v.name_valid = !nm_bad;
      v.has_dot = nm_dot;
      clear_name_state();
      return 1;
   endfunction

   task automatic send_char(input logic [15:0] c, input logic last);
      verdict_type v;
      if (!quiet && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_char_code <= c;
      req_is_last <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (validate_char(c, last, v)) verdicts_due.push_back(v);
      accepted++;
      @(negedge clock);
   endtask

   task automatic send_name(input string s);
      for (int k = 0; k < s.len(); k++) send_char(16'(s[k]), k == s.len() - 1);
   endtask

   task automatic drain_and_write(input logic idx, input logic [7:0] val);
      req_valid <= 1'b0;
      while (verdicts_due.size() != 0) @(negedge clock);
      repeat (400) @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_SINGLE_LABEL) single_limit = val[SLL_W-1:0];
      else name_limit = val;
   endtask

   function automatic logic [15:0] rand_char();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40) return 16'("a" + $urandom_range(0, 25));
      if (r < 48) return 16'("A" + $urandom_range(0, 25));
      if (r < 62) return 16'("0" + $urandom_range(0, 9));
      if (r < 72) return 16'("-");
      if (r < 76) return 16'("_");
      if (r < 86) return 16'(".");
      if (r < 93) return 16'($urandom_range(0, 255));
      return 16'($urandom_range(0, 65535));
   endfunction

   function automatic string rand_label(input int n, input bit puny);
      string s;
      string alpha;
      alpha = "abcdefghijklmnopqrstuvwxyz0123456789";
      s = puny ? "xn--" : "";
      for (int k = 0; k < n; k++) begin
         if (puny && $urandom_range(0, 9) == 0) s = {s, "-"};
         else if (!puny && k != 0 && k != n - 1 && $urandom_range(0, 7) == 0)
            s = {s, "-"};
         else s = {s, string'(alpha[$urandom_range(0, 35)])};
      end
      return s;
   endfunction

   always @(posedge clock) begin
      verdict_type w;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (verdicts_due.size() == 0) report("response with no name pending");
         else begin
            w = verdicts_due.pop_front();
            if (rsp_name_valid !== w.name_valid)
               report($sformatf("name_valid %b want %b", rsp_name_valid, w.name_valid));
            if (rsp_has_dot !== w.has_dot)
               report($sformatf("has_dot %b want %b", rsp_has_dot, w.has_dot));
         end
      end
   end

   // receiver stall bursts
   initial begin
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_stall <= 1'b1;
            repeat (LONG_IDLE_CYCLES) @(negedge clock);
            hold_rsp = 1'b0;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 15)) @(negedge clock);
         end else begin
            rsp_stall <= 1'b0;
            @(negedge clock);
         end
      end
   end

   initial begin
      #50ms;
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      stim_row_type rows[$];
      string        s;
      int           total;
      single_limit = SLL_RESET;
      name_limit = NLL_RESET;
      clear_name_state();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: character code, last item, expectation known?, expectation
      rows = '{
         '{16'h002E, 1'b1, 1'b1, 2'b00},   // all dots
         '{16'h0061, 1'b1, 1'b1, 2'b10},
         '{16'hFFFF, 1'b1, 1'b1, 2'b00},
         '{16'h0000, 1'b1, 1'b1, 2'b00},
         '{16'h002D, 1'b1, 1'b1, 2'b00},
         '{16'h005F, 1'b1, 1'b1, 2'b10},
         '{16'h002E, 1'b0, 1'b0, 2'b00},   // leading dot
         '{16'h0061, 1'b1, 1'b1, 2'b01},
         '{16'h0061, 1'b0, 1'b0, 2'b00},   // double dot
         '{16'h002E, 1'b0, 1'b0, 2'b00},
         '{16'h002E, 1'b0, 1'b0, 2'b00},
         '{16'h0062, 1'b1, 1'b1, 2'b01},
         '{16'h0041, 1'b0, 1'b0, 2'b00},   // trailing dot stripped
         '{16'h002E, 1'b1, 1'b1, 2'b10},
         '{16'h8061, 1'b1, 1'b1, 2'b00}    // high byte makes it illegal
      };
      foreach (rows[r]) begin
         send_char(rows[r].ch, rows[r].last);
         if (rows[r].known && rows[r].last && verdicts_due.size() != 0 &&
             verdicts_due[$] !== rows[r].want)
            report($sformatf("directed row %0d predicts %b", r, verdicts_due[$]));
      end
      send_name("xn--bcher-kva.example");
      send_name("XN--mnchen-3ya.de");
      send_name("xn--_bad.com");
      send_name("xn--99999999999.com");
      send_name("abc-.de");
      send_name("sixteen-chars-ab");
      send_name({rand_label(63, 0), ".", rand_label(64, 0)});

      drain_and_write(CSR_SINGLE_LABEL, 8'd63);
      drain_and_write(CSR_NAME_LENGTH, 8'd255);
      send_name({rand_label(63, 0), ".", rand_label(63, 0), ".", rand_label(63, 0),
                 ".", rand_label(63, 0)});
      send_name(rand_label(63, 0));
      drain_and_write(CSR_SINGLE_LABEL, 8'd0);
      drain_and_write(CSR_NAME_LENGTH, 8'd0);
      send_name("a");
      send_name("a.b");
      drain_and_write(CSR_SINGLE_LABEL, 8'd1);
      drain_and_write(CSR_NAME_LENGTH, 8'd1);
      send_name("a");
      send_name("ab");

      total = 0;
      for (int phase = 0; phase < 4; phase++) begin
         drain_and_write(CSR_SINGLE_LABEL, phase == 0 ? 8'd15 : 8'($urandom_range(1, 63)));
         drain_and_write(CSR_NAME_LENGTH, phase == 0 ? 8'd253 : 8'($urandom_range(8, 255)));
         if (phase == 1) hold_rsp = 1'b1;
         if (phase == 3) quiet = 1'b1;
         while (total < (phase + 1) * 350) begin
            if ($urandom_range(0, 9) < 8) begin
               s = "";
               for (int l = $urandom_range(1, 4); l > 0; l--) begin
                  if (s.len() != 0) s = {s, "."};
                  s = {s, rand_label($urandom_range(1, 12), $urandom_range(0, 2) == 0)};
               end
               if ($urandom_range(0, 9) == 0) s = {s, "."};
               send_name(s);
               total += s.len();
            end else begin
               for (int k = $urandom_range(1, 10); k > 0; k--) begin
                  send_char(rand_char(), k == 1);
                  total++;
               end
            end
         end
      end

      req_valid <= 1'b0;
      while (verdicts_due.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (fail_count == 0) $display("ALL CHECKS PASSED");
      else $display("CHECKS FAILED");
      $finish;
   end
endmodule
